/* design/run_slice_line_rasterizer_macros.svh */
// Assertion macros used by the run-slice line rasterizer checker.
`ifndef RUN_SLICE_LINE_RASTERIZER_MACROS_SVH
`define RUN_SLICE_LINE_RASTERIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSLR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* design/rslr_pkg.sv */
// Types and constants shared by the run-slice line rasterizer.
package rslr_pkg;

  localparam int COLOR_BITS = 8;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_VERT = 3'd1,
    MODE_HORZ = 3'd2,
    MODE_DIAG = 3'd3,
    MODE_XMAJ = 3'd4,
    MODE_YMAJ = 3'd5
  } line_mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } state_t;

endpackage

/* design/rslr_if.sv */
// Request and pixel channel interfaces of the run-slice line rasterizer.
interface rslr_req_if #(
  parameter int COORD_BITS = 10
);
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [COORD_BITS-1:0]           start_x;
  logic [COORD_BITS-1:0]           start_y;
  logic [COORD_BITS-1:0]           end_x;
  logic [COORD_BITS-1:0]           end_y;
  logic [rslr_pkg::COLOR_BITS-1:0] red_in;
  logic [rslr_pkg::COLOR_BITS-1:0] green_in;
  logic [rslr_pkg::COLOR_BITS-1:0] blue_in;

  modport source (
    output valid, req_type, start_x, start_y, end_x, end_y, red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_x, start_y, end_x, end_y, red_in, green_in, blue_in,
    output ready
  );
endinterface

interface rslr_pix_if #(
  parameter int COORD_BITS = 10
);
  logic                            valid;
  logic                            ready;
  logic                            pixel_valid;
  logic [COORD_BITS-1:0]           pixel_x;
  logic [COORD_BITS-1:0]           pixel_y;
  logic [rslr_pkg::COLOR_BITS-1:0] red_out;
  logic [rslr_pkg::COLOR_BITS-1:0] green_out;
  logic [rslr_pkg::COLOR_BITS-1:0] blue_out;
  logic                            last_pixel;

  modport source (
    output valid, pixel_valid, pixel_x, pixel_y, red_out, green_out, blue_out, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, pixel_x, pixel_y, red_out, green_out, blue_out, last_pixel,
    output ready
  );
endinterface

/* design/rslr_divider.sv */
// Bit-serial restoring divider that yields one quotient bit per cycle.
module rslr_divider #(
  parameter int WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  assign shifted = {rem, quo[WIDTH-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CntW'(WIDTH);
    end else if (busy) begin
      rem <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], fits};
      cnt <= cnt - CntW'(1);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* design/run_slice_line_rasterizer.sv */
// A tick transfer places its pixel in the output register in the cycle after acceptance.
// Ticks and starts of straight lines are taken one per cycle while the output is free.
// A start of a run-slice line drops ready until the bit-serial divider is done, which
// forms the whole run length and its remainder.
// Synchronous active-high rst leaves the line idle and the output register empty.
module run_slice_line_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input logic        clk,
  input logic        rst,
  rslr_req_if.sink   req,
  rslr_pix_if.source pix
);

  localparam int N    = COORD_BITS;
  localparam int RunW = COORD_BITS + 1;
  localparam int ErrW = COORD_BITS + 2;
  localparam int CB   = rslr_pkg::COLOR_BITS;

  rslr_pkg::state_t     state;
  rslr_pkg::state_t     state_next;
  rslr_pkg::line_mode_t line_mode;
  rslr_pkg::line_mode_t start_mode;

  logic [N-1:0]           pos_x;
  logic [N-1:0]           pos_y;
  logic signed [ErrW-1:0] error_term;
  logic [RunW-1:0]        adjust_up;
  logic [RunW-1:0]        adjust_down;
  logic [N-1:0]           base_run;
  logic [RunW-1:0]        run_remaining;
  logic [N-1:0]           runs_remaining;
  logic [N-1:0]           final_run;
  logic                   x_step_negative;
  logic                   line_active;
  logic [CB-1:0]          color_r;
  logic [CB-1:0]          color_g;
  logic [CB-1:0]          color_b;
  logic [N-1:0]           minor_reg;

  logic          out_valid;
  logic          o_pixel_valid;
  logic [N-1:0]  o_x;
  logic [N-1:0]  o_y;
  logic [CB-1:0] o_r;
  logic [CB-1:0] o_g;
  logic [CB-1:0] o_b;
  logic          o_last;

  logic in_ready;
  logic accept;
  logic start_fire;
  logic tick_fire;
  logic div_start;
  logic div_done;
  logic [N-1:0] div_quo;
  logic [N-1:0] div_rem;

  logic         swap;
  logic [N-1:0] x0, y0, x1, y1;
  logic         neg;
  logic [N-1:0] dx, dy, major, minor;
  logic         x_major;
  logic [RunW-1:0] straight_run;

  logic [N-1:0]    first;
  logic [N-1:0]    first_adj;
  logic [ErrW-1:0] setup_err;

  logic            runs_mode;
  logic            tick_last;
  logic [RunW-1:0] rr_dec;
  logic [N-1:0]    px_step;
  logic [N-1:0]    py_step;
  logic signed [ErrW-1:0] err_add;
  logic signed [ErrW-1:0] err_sub;
  logic            err_pos;

  // Endpoint ordering and line classification for a start request.
  always_comb begin
    swap    = req.start_y > req.end_y;
    x0      = swap ? req.end_x   : req.start_x;
    y0      = swap ? req.end_y   : req.start_y;
    x1      = swap ? req.start_x : req.end_x;
    y1      = swap ? req.start_y : req.end_y;
    neg     = x1 < x0;
    dx      = neg ? x0 - x1 : x1 - x0;
    dy      = y1 - y0;
    x_major = dx > dy;
    major   = x_major ? dx : dy;
    minor   = x_major ? dy : dx;
    if (dx == '0) begin
      start_mode = rslr_pkg::MODE_VERT;
    end else if (dy == '0) begin
      start_mode = rslr_pkg::MODE_HORZ;
    end else if (dx == dy) begin
      start_mode = rslr_pkg::MODE_DIAG;
    end else if (x_major) begin
      start_mode = rslr_pkg::MODE_XMAJ;
    end else begin
      start_mode = rslr_pkg::MODE_YMAJ;
    end
    straight_run = (start_mode == rslr_pkg::MODE_VERT) ? RunW'(dy) + RunW'(1)
                                                       : RunW'(dx) + RunW'(1);
  end

  // Run parameters formed from the quotient and remainder.
  always_comb begin
    first     = {1'b0, div_quo[N-1:1]} + N'(1);
    first_adj = (div_rem == '0 && !div_quo[0]) ? first - N'(1) : first;
    setup_err = {2'b00, div_rem} - {1'b0, minor_reg, 1'b0}
              + (div_quo[0] ? {2'b00, minor_reg} : ErrW'(0));
  end

  // Stepping terms for a tick.
  always_comb begin
    runs_mode = line_mode == rslr_pkg::MODE_XMAJ || line_mode == rslr_pkg::MODE_YMAJ;
    if (runs_mode) begin
      tick_last = run_remaining <= RunW'(1) && runs_remaining == '0 && final_run == '0;
    end else begin
      tick_last = run_remaining <= RunW'(1);
    end
    rr_dec  = (run_remaining != '0) ? run_remaining - RunW'(1) : run_remaining;
    px_step = x_step_negative ? pos_x - N'(1) : pos_x + N'(1);
    py_step = pos_y + N'(1);
    err_add = error_term + $signed({1'b0, adjust_up});
    err_sub = err_add - $signed({1'b0, adjust_down});
    err_pos = !err_add[ErrW-1] && (err_add != '0);
  end

  always_comb begin
    in_ready   = (state == rslr_pkg::ST_IDLE) && (!out_valid || pix.ready);
    accept     = req.valid && in_ready;
    start_fire = accept && (req.req_type == rslr_pkg::REQ_START);
    tick_fire  = accept && (req.req_type == rslr_pkg::REQ_TICK);
    div_start  = start_fire && (start_mode == rslr_pkg::MODE_XMAJ ||
                                start_mode == rslr_pkg::MODE_YMAJ);
    state_next = state;
    case (state)
      rslr_pkg::ST_IDLE: begin
        if (div_start) begin
          state_next = rslr_pkg::ST_DIVIDE;
        end
      end
      rslr_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = rslr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rslr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rslr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  rslr_divider #(
    .WIDTH(N)
  ) u_rslr_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (major),
    .divisor  (minor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      line_mode   <= rslr_pkg::MODE_IDLE;
    end else if (start_fire) begin
      line_active     <= 1'b1;
      line_mode       <= start_mode;
      x_step_negative <= neg;
      pos_x           <= x0;
      pos_y           <= y0;
      color_r         <= req.red_in;
      color_g         <= req.green_in;
      color_b         <= req.blue_in;
      minor_reg       <= minor;
      error_term      <= '0;
      adjust_up       <= '0;
      adjust_down     <= '0;
      base_run        <= '0;
      runs_remaining  <= '0;
      final_run       <= '0;
      run_remaining   <= straight_run;
    end else if (div_done) begin
      base_run       <= div_quo;
      adjust_up      <= {div_rem, 1'b0};
      adjust_down    <= {minor_reg, 1'b0};
      error_term     <= setup_err;
      final_run      <= first;
      run_remaining  <= RunW'(first_adj);
      runs_remaining <= minor_reg - N'(1);
    end else if (tick_fire && line_active) begin
      if (!runs_mode) begin
        run_remaining <= rr_dec;
        if (line_mode == rslr_pkg::MODE_HORZ || line_mode == rslr_pkg::MODE_DIAG) begin
          pos_x <= px_step;
        end
        if (line_mode == rslr_pkg::MODE_VERT || line_mode == rslr_pkg::MODE_DIAG) begin
          pos_y <= py_step;
        end
        if (rr_dec == '0) begin
          line_active <= 1'b0;
        end
      end else begin
        if (line_mode == rslr_pkg::MODE_XMAJ) begin
          pos_x <= px_step;
        end else begin
          pos_y <= py_step;
        end
        if (rr_dec != '0) begin
          run_remaining <= rr_dec;
        end else begin
          if (line_mode == rslr_pkg::MODE_XMAJ) begin
            pos_y <= py_step;
          end else begin
            pos_x <= px_step;
          end
          if (runs_remaining != '0) begin
            runs_remaining <= runs_remaining - N'(1);
            if (err_pos) begin
              run_remaining <= RunW'(base_run) + RunW'(1);
              error_term    <= err_sub;
            end else begin
              run_remaining <= RunW'(base_run);
              error_term    <= err_add;
            end
          end else if (final_run != '0) begin
            run_remaining <= RunW'(final_run);
            final_run     <= '0;
          end else begin
            run_remaining <= rr_dec;
            line_active   <= 1'b0;
          end
        end
      end
    end
  end

  // Output register; it is freed when its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      if (line_active) begin
        o_pixel_valid <= 1'b1;
        o_x           <= pos_x;
        o_y           <= pos_y;
        o_r           <= color_r;
        o_g           <= color_g;
        o_b           <= color_b;
        o_last        <= tick_last;
      end else begin
        o_pixel_valid <= 1'b0;
        o_x           <= '0;
        o_y           <= '0;
        o_r           <= '0;
        o_g           <= '0;
        o_b           <= '0;
        o_last        <= 1'b0;
      end
    end
  end

  assign req.ready       = in_ready;
  assign pix.valid       = out_valid;
  assign pix.pixel_valid = o_pixel_valid;
  assign pix.pixel_x     = o_x;
  assign pix.pixel_y     = o_y;
  assign pix.red_out     = o_r;
  assign pix.green_out   = o_g;
  assign pix.blue_out    = o_b;
  assign pix.last_pixel  = o_last;

endmodule

/* design/rslr_checker.sv */
// Port-level checker for the run-slice line rasterizer, with its bind.
`include "run_slice_line_rasterizer_macros.svh"

module rslr_checker #(
  parameter int COORD_BITS = 10
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_req_type,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_pixel_valid,
  input logic [COORD_BITS-1:0]           out_x,
  input logic [COORD_BITS-1:0]           out_y,
  input logic [rslr_pkg::COLOR_BITS-1:0] out_r,
  input logic [rslr_pkg::COLOR_BITS-1:0] out_g,
  input logic [rslr_pkg::COLOR_BITS-1:0] out_b,
  input logic                            out_last
);

  logic start_xfer;
  logic tick_xfer;
  logic out_stall;

  assign start_xfer = in_valid && in_ready && (in_req_type == rslr_pkg::REQ_START);
  assign tick_xfer  = in_valid && in_ready && (in_req_type == rslr_pkg::REQ_TICK);
  assign out_stall  = out_valid && !out_ready;

  `RSLR_ASSERT_NEXT(a_stall_holds, out_stall, out_valid && $stable(out_pixel_valid) && $stable(out_x) && $stable(out_y) && $stable(out_r) && $stable(out_g) && $stable(out_b) && $stable(out_last))
  `RSLR_ASSERT_NEXT(a_start_no_result, start_xfer, !out_valid)
  `RSLR_ASSERT_NEXT(a_tick_gives_result, tick_xfer, out_valid)
  `RSLR_ASSERT_SAME(a_last_is_pixel, out_valid && out_last, out_pixel_valid)

endmodule

bind run_slice_line_rasterizer rslr_checker #(
  .COORD_BITS(COORD_BITS)
) u_rslr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .in_req_type    (req.req_type),
  .out_valid      (pix.valid),
  .out_ready      (pix.ready),
  .out_pixel_valid(pix.pixel_valid),
  .out_x          (pix.pixel_x),
  .out_y          (pix.pixel_y),
  .out_r          (pix.red_out),
  .out_g          (pix.green_out),
  .out_b          (pix.blue_out),
  .out_last       (pix.last_pixel)
);
